// ===== hdl/swcp_pkg.sv =====
`default_nettype none

package swcp_pkg;

    localparam int COUNT_W   = 5;
    localparam int PEN_W     = 8;
    localparam int TAIL_W    = 12;
    localparam int TOTAL_W   = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_STATION_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_CAPACITIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_WINDOWS    = 2'd2;

    typedef struct packed {
        logic [7:0] needs_mask;
        logic       first_car;
        logic       last_car;
    } swcp_car_t;

    typedef struct packed {
        logic [7:0]  position_penalty;
        logic [9:0]  tail_penalty;
        logic [23:0] running_total;
        logic        sequence_done;
    } swcp_result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               dec;
        logic               inc;
        logic [3:0]         cap;
    } swcp_op_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_new;
        logic [COUNT_W-1:0] excess;
    } swcp_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_TAIL_LOAD,
        ST_TAIL_WALK,
        ST_FINISH
    } swcp_state_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_capacity_penalty.sv =====
`default_nettype none
// Flow: an accepted word steps through every station in turn in the shared count unit,
// then a finish step loads the result register. A last car adds a tail walk over the
// active stations, through each station's window, before the finish step.
// The input stalls until the result is loaded, which a held result word delays.
// Reset: asynchronous, active low; clears history, counts, total and loads register
// defaults.

module sliding_window_capacity_penalty
    import swcp_pkg::*;
#(
    parameter int STATIONS   = 8,
    parameter int MAX_WINDOW = 16
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  car_valid,
    output logic                 car_stall,
    input  wire swcp_car_t       car,
    output logic                 result_valid,
    input  wire                  result_stall,
    output swcp_result_t         result,
    input  wire                  cfg_write,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_data
);

    localparam int S_CNT_W = $clog2(STATIONS + 1);
    localparam int SIDX_W  = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int HIST_W  = $clog2(MAX_WINDOW);

    swcp_state_t state_reg, state_next;

    logic [3:0]       station_count_reg;
    logic [CFG_W-1:0] caps_reg;
    logic [CFG_W-1:0] windows_reg;

    logic [7:0]         hist_reg [MAX_WINDOW];
    logic [COUNT_W-1:0] count_reg [STATIONS];
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [7:0]         mask_reg;
    logic               last_reg;
    logic [S_CNT_W-1:0] s_reg, s_next;
    logic [HIST_W-1:0]  j_reg, j_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [PEN_W-1:0]   pen_reg, pen_next;
    logic [TAIL_W-1:0]  tail_reg, tail_next;

    logic               result_valid_reg, result_valid_next;
    swcp_result_t       result_reg;

    logic [SIDX_W-1:0]  s_idx;
    logic [3:0]         win_nib;
    logic [HIST_W-1:0]  win_m1;
    logic [3:0]         cap_s;
    logic [HIST_W-1:0]  hist_addr;
    logic [7:0]         hist_rd;
    logic               s_last;
    logic               s_active;
    logic               tail_done;
    logic               accept;
    logic               load_result;
    logic               use_tail_op;
    logic [TOTAL_W:0]   total_sum;
    swcp_op_t           op;
    swcp_res_t          res;

    assign s_idx    = s_reg[SIDX_W-1:0];
    assign win_nib  = windows_reg[{s_idx, 2'b00} +: 4];
    assign cap_s    = caps_reg[{s_idx, 2'b00} +: 4];
    assign win_m1   = (int'(win_nib) > MAX_WINDOW - 1) ? HIST_W'(MAX_WINDOW - 1)
                                                       : HIST_W'(win_nib);
    assign s_last   = (s_reg == S_CNT_W'(STATIONS - 1));
    assign s_active = ({1'b0, s_reg} < (S_CNT_W+1)'(station_count_reg));
    assign tail_done = (s_reg == S_CNT_W'(STATIONS)) || !s_active;
    assign hist_addr = use_tail_op ? j_reg : win_m1;
    assign hist_rd   = hist_reg[hist_addr];

    always_comb
    begin
        op.count = use_tail_op ? k_reg : count_reg[s_idx];
        op.dec   = hist_rd[s_idx];
        op.inc   = use_tail_op ? 1'b0 : mask_reg[s_idx];
        op.cap   = cap_s;
    end

    swcp_unit u_unit
    (
        .op  (op),
        .res (res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (car_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (s_last)
                begin
                    state_next = last_reg ? ST_TAIL_LOAD : ST_FINISH;
                end
            end
            ST_TAIL_LOAD:
            begin
                if (tail_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (win_m1 != '0)
                begin
                    state_next = ST_TAIL_WALK;
                end
            end
            ST_TAIL_WALK:
            begin
                if (j_reg == HIST_W'(1))
                begin
                    state_next = ST_TAIL_LOAD;
                end
            end
            ST_FINISH:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        car_stall   = 1'b1;
        use_tail_op = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            ST_IDLE:      car_stall   = 1'b0;
            ST_TAIL_WALK: use_tail_op = 1'b1;
            ST_FINISH:    load_result = !result_valid_reg || !result_stall;
            default:      car_stall   = 1'b1;
        endcase
    end

    assign accept = car_valid && !car_stall;

    always_comb
    begin
        s_next    = s_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        pen_next  = pen_reg;
        tail_next = tail_reg;
        total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(pen_reg) + (TOTAL_W+1)'(tail_reg);
        total_next = total_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                s_next    = '0;
                pen_next  = '0;
                tail_next = '0;
                if (accept && car.first_car)
                begin
                    total_next = '0;
                end
            end
            ST_UPDATE:
            begin
                if (s_active)
                begin
                    pen_next = pen_reg + PEN_W'(res.excess);
                end
                s_next = s_last ? '0 : s_reg + S_CNT_W'(1);
            end
            ST_TAIL_LOAD:
            begin
                if (!tail_done)
                begin
                    k_next = count_reg[s_idx];
                    j_next = win_m1;
                    if (win_m1 == '0)
                    begin
                        s_next = s_reg + S_CNT_W'(1);
                    end
                end
            end
            ST_TAIL_WALK:
            begin
                k_next    = res.count_new;
                tail_next = tail_reg + TAIL_W'(res.excess);
                j_next    = j_reg - HIST_W'(1);
                if (j_reg == HIST_W'(1))
                begin
                    s_next = s_reg + S_CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (load_result)
                begin
                    total_next = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                               : total_sum[TOTAL_W-1:0];
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            station_count_reg <= 4'd1;
            caps_reg          <= '1;
            windows_reg       <= '0;
            total_reg         <= '0;
            result_valid_reg  <= 1'b0;
            s_reg             <= '0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
            for (int i = 0; i < STATIONS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
            s_reg            <= s_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_STATION_COUNT:      station_count_reg <= cfg_data[3:0];
                    REG_STATION_CAPACITIES: caps_reg          <= cfg_data;
                    REG_STATION_WINDOWS:    windows_reg       <= cfg_data;
                    default:                caps_reg          <= caps_reg;
                endcase
            end
            if (accept && car.first_car)
            begin
                for (int i = 0; i < MAX_WINDOW; i++)
                begin
                    hist_reg[i] <= '0;
                end
                for (int i = 0; i < STATIONS; i++)
                begin
                    count_reg[i] <= '0;
                end
            end
            else if (state_reg == ST_UPDATE)
            begin
                count_reg[s_idx] <= res.count_new;
                if (s_last)
                begin
                    for (int i = MAX_WINDOW - 1; i > 0; i--)
                    begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                    hist_reg[0] <= mask_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg <= car.needs_mask;
            last_reg <= car.last_car;
        end
        j_reg    <= j_next;
        k_reg    <= k_next;
        pen_reg  <= pen_next;
        tail_reg <= tail_next;
        if (load_result)
        begin
            result_reg.position_penalty <= pen_reg;
            result_reg.tail_penalty     <= tail_reg[9:0];
            result_reg.running_total    <= total_next;
            result_reg.sequence_done    <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("Result word appeared outside the finish step.");

    a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE) && (s_reg == '0))
        else $error("Accepted word did not start the station pass at station zero.");

    a_tail_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.sequence_done || (result_reg.tail_penalty == '0)))
        else $error("Tail penalty reported on a word that does not close the sequence.");

endmodule

`default_nettype wire

// ===== hdl/swcp_unit.sv =====
`default_nettype none

module swcp_unit
    import swcp_pkg::*;
(
    input  wire swcp_op_t  op,
    output swcp_res_t      res
);

    logic [COUNT_W-1:0] dec_count;
    logic [COUNT_W:0]   inc_count;
    logic [COUNT_W-1:0] sat_count;

    always_comb
    begin
        if (op.dec && (op.count != '0))
        begin
            dec_count = op.count - COUNT_W'(1);
        end
        else
        begin
            dec_count = op.count;
        end
        inc_count = {1'b0, dec_count} + (COUNT_W+1)'(op.inc);
        if (inc_count > {1'b0, COUNT_MAX})
        begin
            sat_count = COUNT_MAX;
        end
        else
        begin
            sat_count = inc_count[COUNT_W-1:0];
        end
        res.count_new = sat_count;
        if (sat_count > COUNT_W'(op.cap))
        begin
            res.excess = sat_count - COUNT_W'(op.cap);
        end
        else
        begin
            res.excess = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    import swcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_CARS = 650;

    class penalty_scoreboard;
        logic [3:0]        reg_count;
        logic [31:0]       reg_caps;
        logic [31:0]       reg_wins;
        logic [7:0]        car_history [16];
        logic [4:0]        station_load [8];
        logic [23:0]       penalty_sum;
        swcp_result_t      expected_results [$];
        int                errors;

        function new();
            reg_count = 4'd1;
            reg_caps = 32'hFFFF_FFFF;
            reg_wins = 32'h0;
            clear_sequence();
            errors = 0;
        endfunction

        function void clear_sequence();
            foreach (car_history[j])
                car_history[j] = 8'h00;
            foreach (station_load[s])
                station_load[s] = 5'd0;
            penalty_sum = 24'd0;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_STATION_COUNT:      reg_count = data[3:0];
                REG_STATION_CAPACITIES: reg_caps = data;
                REG_STATION_WINDOWS:    reg_wins = data;
                default:                ;
            endcase
        endfunction

        function int window_len(int s);
            return int'(reg_wins[4*s +: 4]) + 1;
        endfunction

        function int capacity(int s);
            return int'(reg_caps[4*s +: 4]);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_car(swcp_car_t c);
            int act, pen, tail, n, k, sum, s, j;
            swcp_result_t r;
            act = (reg_count > 4'd8) ? 8 : int'(reg_count);
            pen = 0;
            tail = 0;
            if (c.first_car)
                clear_sequence();
            for (s = 0; s < 8; s++)
            begin
                n = window_len(s);
                k = station_load[s];
                if (k > 0 && car_history[n-1][s])
                    k--;
                k += c.needs_mask[s];
                if (k > 31)
                    k = 31;
                station_load[s] = 5'(k);
                if (s < act && k > capacity(s))
                    pen += k - capacity(s);
            end
            for (j = 15; j > 0; j--)
                car_history[j] = car_history[j-1];
            car_history[0] = c.needs_mask;
            if (c.last_car)
            begin
                for (s = 0; s < act; s++)
                begin
                    k = station_load[s];
                    for (j = window_len(s) - 1; j >= 1; j--)
                    begin
                        if (k > 0 && car_history[j][s])
                            k--;
                        if (k > capacity(s))
                            tail += k - capacity(s);
                    end
                end
            end
            sum = int'(penalty_sum) + pen + tail;
            if (sum > int'(TOTAL_MAX))
                sum = int'(TOTAL_MAX);
            penalty_sum = 24'(sum);
            r.position_penalty = 8'(pen);
            r.tail_penalty = 10'(tail);
            r.running_total = penalty_sum;
            r.sequence_done = c.last_car;
            expected_results.push_back(r);
        endfunction

        function void check_result(swcp_result_t got);
            swcp_result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result word %h with nothing outstanding.", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.position_penalty !== want.position_penalty
                || got.tail_penalty !== want.tail_penalty
                || got.running_total !== want.running_total
                || got.sequence_done !== want.sequence_done)
            begin
                errors++;
                if (errors <= 10)
                    $display({"Result mismatch: expected pen=%0d tail=%0d total=%0d done=%0b,",
                              " got pen=%0d tail=%0d total=%0d done=%0b"},
                             want.position_penalty, want.tail_penalty, want.running_total,
                             want.sequence_done, got.position_penalty, got.tail_penalty,
                             got.running_total, got.sequence_done);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  car_valid = 1'b0;
    logic                  car_stall;
    swcp_car_t             car = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    swcp_result_t          result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    bit                    calm = 1'b0;

    penalty_scoreboard sb = new();

    sliding_window_capacity_penalty dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .car_valid    (car_valid),
        .car_stall    (car_stall),
        .car          (car),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < 17);
        if (rst_n)
        begin
            if (car_valid && !car_stall)
                sb.note_car(car);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    task automatic send_car(logic [7:0] mask, logic first_flag, logic last_flag);
        swcp_car_t c;
        c.needs_mask = mask;
        c.first_car = first_flag;
        c.last_car = last_flag;
        if (!calm)
        begin
            while ($urandom_range(99) < 17)
            begin
                car_valid <= 1'b0;
                @(posedge clk);
            end
        end
        car <= c;
        car_valid <= 1'b1;
        do
            @(posedge clk);
        while (car_stall);
    endtask

    task automatic send_run(int n, logic [7:0] mask, logic opens);
        for (int i = 0; i < n; i++)
            send_car(mask, opens && i == 0, 1'b0);
    endtask

    task automatic wait_idle();
        car_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.apply_config(idx, data);
    endtask

    task automatic configure(logic [3:0] count, logic [31:0] caps, logic [31:0] wins);
        wait_idle();
        write_cfg(REG_UNUSED, $urandom);
        write_cfg(REG_STATION_COUNT, {28'($urandom), count});
        write_cfg(REG_STATION_CAPACITIES, caps);
        write_cfg(REG_STATION_WINDOWS, wins);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] rand_nibbles(int limit);
        logic [31:0] v;
        for (int i = 0; i < 8; i++)
            v[4*i +: 4] = 4'($urandom_range(limit));
        return v;
    endfunction

    initial
    begin
        int sent;
        int seq_left;
        int phase_len;
        logic first_flag;
        logic last_flag;
        logic [7:0] mask;
        logic [3:0] count;
        logic [31:0] caps;
        logic [31:0] wins;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state acts as a fresh sequence.
        send_car(8'hFF, 1'b0, 1'b0);
        send_car(8'h00, 1'b0, 1'b1);

        configure(4'd8, 32'h0, 32'h0);
        send_car(8'hFF, 1'b1, 1'b0);
        send_car(8'hFF, 1'b0, 1'b0);
        send_car(8'h55, 1'b0, 1'b0);
        send_car(8'hAA, 1'b0, 1'b1);
        send_car(8'h0F, 1'b0, 1'b0);
        send_car(8'hF0, 1'b0, 1'b1);

        // Windows longer than the sequence.
        configure(4'd8, 32'h1111_1111, 32'hFFFF_FFFF);
        send_car(8'hFF, 1'b1, 1'b0);
        send_car(8'hFF, 1'b0, 1'b0);
        send_car(8'hFF, 1'b0, 1'b1);

        configure(4'd0, 32'h0, 32'h0);
        send_car(8'hFF, 1'b1, 1'b1);
        send_car(8'hFF, 1'b0, 1'b1);

        configure(4'd15, 32'h0, 32'h1357_9BDF);
        send_car(8'hFF, 1'b1, 1'b0);
        send_car(8'hFF, 1'b0, 1'b1);

        configure(4'd9, 32'h0, 32'h0123_4567);
        send_car(8'hFF, 1'b1, 1'b0);
        send_car(8'($urandom), 1'b0, 1'b0);
        send_car(8'($urandom), 1'b0, 1'b0);
        send_car(8'hFF, 1'b0, 1'b1);

        sent = 0;
        seq_left = 0;
        while (sent < RANDOM_CARS)
        begin
            case ($urandom_range(4))
                0:       count = 4'd0;
                1:       count = 4'd1;
                2:       count = 4'd8;
                3:       count = 4'd15;
                default: count = 4'($urandom_range(15));
            endcase
            case ($urandom_range(3))
                0:       caps = 32'h0;
                1:       caps = 32'hFFFF_FFFF;
                2:       caps = $urandom;
                default: caps = rand_nibbles(3);
            endcase
            case ($urandom_range(3))
                0:       wins = 32'h0;
                1:       wins = 32'hFFFF_FFFF;
                2:       wins = $urandom;
                default: wins = rand_nibbles(5);
            endcase
            configure(count, caps, wins);
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len; i++)
            begin
                calm = (sent >= 250 && sent < 400);
                if (seq_left == 0)
                begin
                    seq_left = $urandom_range(1, 24);
                    first_flag = ($urandom_range(9) != 0);
                end
                else
                    first_flag = 1'b0;
                seq_left--;
                last_flag = (seq_left == 0);
                if ($urandom_range(9) == 0)
                begin
                    first_flag = 1'($urandom);
                    last_flag = 1'($urandom);
                end
                case ($urandom_range(3))
                    0:       mask = 8'($urandom);
                    1:       mask = 8'($urandom & $urandom);
                    2:       mask = 8'($urandom | $urandom);
                    default: mask = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                send_car(mask, first_flag, last_flag);
                sent++;
            end
        end
        calm = 1'b0;

        // Window changes in mid-sequence push the station counts to their ceiling.
        configure(4'd8, 32'h0, 32'hFFFF_FFFF);
        send_run(16, 8'hFF, 1'b1);
        for (int round = 0; round < 2; round++)
        begin
            configure(4'd8, 32'h0, 32'h0);
            send_run(16, 8'h00, 1'b0);
            configure(4'd8, 32'h0, 32'hFFFF_FFFF);
            send_run(16, 8'hFF, 1'b0);
        end

        // Tail penalties with the counts held at their ceiling.
        repeat (3) send_car(8'hFF, 1'b0, 1'b1);

        // Counts that would fall below zero after the window grows.
        configure(4'd8, 32'h0, 32'h0);
        send_run(16, 8'hFF, 1'b1);
        configure(4'd8, 32'h0, 32'hFFFF_FFFF);
        send_run(3, 8'h00, 1'b0);
        send_car(8'h00, 1'b0, 1'b1);

        wait_idle();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/swcp_pkg.sv
hdl/swcp_unit.sv
hdl/sliding_window_capacity_penalty.sv
sim/testbench.sv
